### src/ffal_pkg.sv
// ----------------------------------------------------------------------------
// ffal_pkg
// Shared types and constants for the first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffal_pkg;

  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 12;
  localparam int ALIGN_BYTES  = 8;
  localparam int OFF_W        = 12;
  localparam int SIZE_W       = 13;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_NOFIT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RS_ZERO  = 2'd0,
    RS_ALLOC = 2'd1,
    RS_FREE  = 2'd2
  } res_sel_t;

  typedef enum logic [0:0] {
    K_ALLOC = 1'b0,
    K_FREE  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [0:0]       kind;
    logic [OFF_W-1:0] request_size;
    logic [OFF_W-1:0] free_offset;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0] data_offset;
    logic [1:0]       status;
  } out_item_t;

  typedef struct packed {
    logic     rebuild;
    logic     load;
    logic     rd;
    logic     adv;
    logic     latch_link;
    logic     wr_split;
    logic     wr_cur;
    logic     wr_link;
    logic     free_op;
    logic     res_load;
    status_t  res_status;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic req_zero;
    logic head_live;
    logic fit;
    logic split_ok;
    logic walk_stop;
  } stat_t;

endpackage

### src/first_fit_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_unit
// First-fit heap allocator with block splitting over an arena of up to 4 KiB.
// ----------------------------------------------------------------------------
// A free, a zero-size request, or an allocate on an empty list returns its
// result in the next cycle. An allocate walks the free list one header at a
// time (memory read, then compare) until a block fits, then unlinks it in the
// link state or splits it in the split state before the link state. A walk
// that finds nothing answers straight after its last test. After reset
// the arena is rebuilt in the init state before the first item is taken; a
// heap_size write rebuilds it at once. Status 2 reports that no block fits.
module first_fit_free_list_allocator_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [12:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffal_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ffal_pkg::out_item_t out_item
);
  import ffal_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ffal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffal_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

### src/ffal_dp.sv
// ----------------------------------------------------------------------------
// ffal_dp
// Datapath: header memories, list head, walk registers and result register.
// ----------------------------------------------------------------------------
module ffal_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [12:0]       cfg_data,
  input  ffal_pkg::in_item_t in_item,
  input  ffal_pkg::cmd_t    cmd,
  output ffal_pkg::stat_t   stat,
  output ffal_pkg::out_item_t out_item
);
  import ffal_pkg::*;

  logic [SIZE_W-1:0] size_mem [HEAP_BYTES];
  logic [OFF_W:0]    next_mem [HEAP_BYTES];   // {link, next}

  logic [SIZE_W-1:0] heap_size;
  logic [OFF_W-1:0]  head;
  logic              live;
  logic [OFF_W-1:0]  cur, prev;
  logic              at_head;
  logic [SIZE_W-1:0] need;
  logic [OFF_W-1:0]  steps;
  logic [SIZE_W-1:0] rd_size;
  logic [OFF_W:0]    rd_next;
  logic [OFF_W:0]    link_tgt;

  logic              rebuild;
  logic [SIZE_W-1:0] new_heap, arena, base_size;
  logic [SIZE_W-1:0] need_next;
  logic [SIZE_W:0]   split_pos;
  logic [OFF_W-1:0]  split_addr;
  logic [OFF_W-1:0]  free_blk;
  logic              free_in;
  logic              size_we, next_we;
  logic [OFF_W-1:0]  size_wa, next_wa;
  logic [SIZE_W-1:0] size_wd;
  logic [OFF_W:0]    next_wd;

  assign rebuild  = cmd.rebuild || cfg_we;
  assign new_heap = cfg_we ? cfg_data : heap_size;
  assign arena    = (new_heap > SIZE_W'(HEAP_BYTES)) ? SIZE_W'(HEAP_BYTES) : new_heap;
  assign base_size = (arena > SIZE_W'(HEADER_BYTES)) ? arena - SIZE_W'(HEADER_BYTES)
                                                     : '0;
  assign need_next = ({1'b0, in_item.request_size} + SIZE_W'(ALIGN_BYTES - 1))
                     & ~SIZE_W'(ALIGN_BYTES - 1);
  assign split_pos  = (SIZE_W+1)'(cur) + (SIZE_W+1)'(HEADER_BYTES) + (SIZE_W+1)'(need);
  assign split_addr = split_pos[OFF_W-1:0];
  assign free_blk   = in_item.free_offset - OFF_W'(HEADER_BYTES);
  // heap_size is not changing here, so the stored value gives the arena
  assign free_in = (in_item.free_offset >= OFF_W'(HEADER_BYTES)) &&
                   ({1'b0, free_blk} < ((heap_size > SIZE_W'(HEAP_BYTES)) ?
                    SIZE_W'(HEAP_BYTES) : heap_size));

  assign stat.req_zero  = (in_item.request_size == '0);
  assign stat.head_live = live;
  assign stat.fit       = (rd_size >= need);
  assign stat.split_ok  = ({1'b0, rd_size} >= ({1'b0, need} +
                           (SIZE_W+1)'(HEADER_BYTES + ALIGN_BYTES))) &&
                          (split_pos < (SIZE_W+1)'(HEAP_BYTES));
  assign stat.walk_stop = !rd_next[OFF_W] || (steps == {OFF_W{1'b1}});

  always_comb begin
    size_we = 1'b0;
    size_wa = '0;
    size_wd = '0;
    next_we = 1'b0;
    next_wa = '0;
    next_wd = '0;
    if (rebuild) begin
      size_we = 1'b1;
      size_wd = base_size;
      next_we = 1'b1;
    end else if (cmd.wr_split) begin
      size_we = 1'b1;
      size_wa = split_addr;
      size_wd = rd_size - need - SIZE_W'(HEADER_BYTES);
      next_we = 1'b1;
      next_wa = split_addr;
      next_wd = rd_next;
    end else if (cmd.wr_cur) begin
      size_we = 1'b1;
      size_wa = cur;
      size_wd = need;
      next_we = 1'b1;
      next_wa = cur;
    end else if (cmd.wr_link) begin
      next_we = !at_head;
      next_wa = prev;
      next_wd = link_tgt;
    end else if (cmd.free_op) begin
      next_we = free_in;
      next_wa = free_blk;
      next_wd = {live, head};
    end
  end

  always_ff @(posedge clk) begin
    if (size_we) size_mem[size_wa] <= size_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (cmd.rd) begin
      rd_size <= size_mem[cur];
      rd_next <= next_mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_size <= SIZE_W'(HEAP_BYTES);
      head      <= '0;
      live      <= 1'b1;
    end else if (rebuild) begin
      heap_size <= new_heap;
      head      <= '0;
      live      <= 1'b1;
    end else if (cmd.wr_link && at_head) begin
      head <= link_tgt[OFF_W-1:0];
      live <= link_tgt[OFF_W];
    end else if (cmd.free_op && free_in) begin
      head <= free_blk;
      live <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      need    <= need_next;
      cur     <= head;
      prev    <= '0;
      at_head <= 1'b1;
      steps   <= '0;
    end else if (cmd.adv) begin
      prev    <= cur;
      cur     <= rd_next[OFF_W-1:0];
      at_head <= 1'b0;
      steps   <= steps + 1'b1;
    end
    if (cmd.latch_link) begin
      link_tgt <= stat.split_ok ? {1'b1, split_addr} : rd_next;
    end
    if (cmd.res_load) begin
      out_item.status <= cmd.res_status;
      case (cmd.res_sel)
        RS_ALLOC: out_item.data_offset <= cur + OFF_W'(HEADER_BYTES);
        RS_FREE:  out_item.data_offset <= in_item.free_offset;
        default:  out_item.data_offset <= '0;
      endcase
    end
  end

endmodule

### src/ffal_ctrl.sv
// ----------------------------------------------------------------------------
// ffal_ctrl
// Controller: sequences a request through walk, split and relink steps.
// ----------------------------------------------------------------------------
module ffal_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  ffal_pkg::in_item_t in_item,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ffal_pkg::stat_t    stat,
  output ffal_pkg::cmd_t     cmd
);
  import ffal_pkg::*;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_EVAL  = 6'b001000,
    S_SPLIT = 6'b010000,
    S_LINK  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.rebuild = 1'b1;
        state_next  = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_item.kind == K_FREE) begin
            cmd.free_op    = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_sel    = RS_FREE;
          end else if (stat.req_zero) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_ZERO;
          end else if (!stat.head_live) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_NOFIT;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.fit) begin
          cmd.latch_link = 1'b1;
          cmd.wr_split   = stat.split_ok;
          state_next     = stat.split_ok ? S_SPLIT : S_LINK;
        end else if (stat.walk_stop) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NOFIT;
          state_next     = S_IDLE;
        end else begin
          cmd.adv    = 1'b1;
          state_next = S_READ;
        end
      end
      S_SPLIT: begin
        cmd.wr_cur = 1'b1;
        state_next = S_LINK;
      end
      S_LINK: begin
        cmd.wr_link    = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_sel    = RS_ALLOC;
        state_next     = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

### src/ffal_chk.sv
// ----------------------------------------------------------------------------
// ffal_chk
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffal_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input ffal_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input ffal_pkg::out_item_t out_item
);
  import ffal_pkg::*;

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_free_echo: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_item.kind == K_FREE |=>
      out_valid && out_item.status == ST_OK &&
      out_item.data_offset == $past(in_item.free_offset))
    else $error("free not echoed");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_item.kind == K_ALLOC && in_item.request_size == '0 |=>
      out_valid && out_item.status == ST_ZERO && out_item.data_offset == '0)
    else $error("zero size not flagged");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_OK |-> out_item.data_offset == '0 &&
      (out_item.status == ST_ZERO || out_item.status == ST_NOFIT))
    else $error("bad error result");

endmodule

bind first_fit_free_list_allocator_unit ffal_chk u_chk (.*);
